// File: rtl/prts_pkg.sv
`timescale 1ns / 1ps

package prts_pkg;

    typedef enum logic [1:0] {
        OP_LOAD      = 2'd0,
        OP_ROTATE    = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_SCALE     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_QUAD,
        S_CORDIC,
        S_MUL,
        S_FINISH
    } state_t;

    // width of the arctangent table index
    localparam int IDX_W = 5;

    typedef struct packed {
        logic             capture;
        logic             reduce;
        logic             quad;
        logic             step;
        logic [IDX_W-1:0] step_idx;
        logic             mul_en;
        logic [1:0]       mul_idx;
        logic             acc_init;
        logic             acc_en;
        logic [1:0]       acc_idx;
        logic             finish;
        op_t              mode;
    } dp_cmd_t;

    // angles in Q8.8 degrees
    localparam logic signed [19:0] ANGLE_FULL    = 20'sd92160;
    localparam logic signed [19:0] ANGLE_QUARTER = 20'sd23040;
    localparam logic signed [19:0] ANGLE_EIGHTH  = 20'sd11520;

    // 1/K in Q30
    localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

    // atan(2^-i) in degrees, Q8.24
    function automatic logic signed [31:0] atan_deg(input logic [IDX_W-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd754974720;
            5'd1:  v = 32'sd445687602;
            5'd2:  v = 32'sd235489088;
            5'd3:  v = 32'sd119537938;
            5'd4:  v = 32'sd60000934;
            5'd5:  v = 32'sd30029717;
            5'd6:  v = 32'sd15018523;
            5'd7:  v = 32'sd7509720;
            5'd8:  v = 32'sd3754917;
            5'd9:  v = 32'sd1877466;
            5'd10: v = 32'sd938734;
            5'd11: v = 32'sd469367;
            5'd12: v = 32'sd234684;
            5'd13: v = 32'sd117342;
            5'd14: v = 32'sd58671;
            5'd15: v = 32'sd29335;
            5'd16: v = 32'sd14668;
            5'd17: v = 32'sd7334;
            5'd18: v = 32'sd3667;
            5'd19: v = 32'sd1833;
            5'd20: v = 32'sd917;
            5'd21: v = 32'sd458;
            5'd22: v = 32'sd229;
            5'd23: v = 32'sd115;
            5'd24: v = 32'sd57;
            5'd25: v = 32'sd29;
            5'd26: v = 32'sd14;
            5'd27: v = 32'sd7;
            5'd28: v = 32'sd4;
            5'd29: v = 32'sd2;
            5'd30: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/prts_ctrl.sv
`timescale 1ns / 1ps

module prts_ctrl
    import prts_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd
);

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CW-1:0] LAST_STEP = CW'(CORDIC_STEPS - 1);

    state_t        state_reg, state_next;
    op_t           op_reg, op_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    mcnt_reg, mcnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    nprod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_LOAD;
            cnt_reg       <= '0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // rotate needs hi/lo partial products for x and y; scale one each
    assign nprod = (op_reg == OP_ROTATE) ? 3'd4 : 3'd2;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        mcnt_next      = mcnt_reg;
        out_valid_next = out_valid_reg && !out_ready;

        cmd          = '0;
        cmd.mode     = op_reg;
        cmd.step_idx = IDX_W'(cnt_reg);
        cmd.mul_idx  = mcnt_reg[1:0];
        cmd.acc_idx  = 2'(mcnt_reg - 3'd1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    op_next     = op_t'(opcode);
                    mcnt_next   = '0;
                    case (op_t'(opcode))
                        OP_ROTATE: state_next = S_REDUCE;
                        OP_SCALE:  state_next = S_MUL;
                        default:   state_next = S_FINISH;
                    endcase
                end
            end
            S_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = S_QUAD;
            end
            S_QUAD:
            begin
                cmd.quad   = 1'b1;
                cnt_next   = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    mcnt_next  = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                // product of step k is summed in step k+1
                cmd.mul_en   = (mcnt_reg < nprod);
                cmd.acc_init = (mcnt_reg == 3'd0);
                cmd.acc_en   = (mcnt_reg != 3'd0);
                if (mcnt_reg == nprod)
                    state_next = S_FINISH;
                else
                    mcnt_next = mcnt_reg + 3'd1;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/prts_datapath.sv
`timescale 1ns / 1ps

module prts_datapath
    import prts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    input  logic signed [31:0]  load_x,
    input  logic signed [31:0]  load_y,
    input  logic signed [17:0]  angle_degrees,
    input  logic signed [31:0]  shift_x,
    input  logic signed [31:0]  shift_y,
    input  logic signed [15:0]  scale_x,
    input  logic signed [15:0]  scale_y,
    output logic signed [31:0]  result_x,
    output logic signed [31:0]  result_y,
    output logic                saturated
);

    localparam int WW = 35;   // CORDIC working width
    localparam int AW = 68;   // accumulator width
    localparam int RW = 40;   // pre-clamp result width

    // captured item
    logic signed [31:0] ld_x_reg, ld_y_reg, sh_x_reg, sh_y_reg;
    logic signed [17:0] ang_reg;
    logic signed [15:0] sc_x_reg, sc_y_reg;

    logic signed [31:0] point_x_reg, point_y_reg;
    logic signed [19:0] mod_reg;
    logic signed [WW-1:0] wx_reg, wy_reg;
    logic signed [32:0] z_reg;
    logic signed [62:0] prod_reg;
    logic signed [AW-1:0] acc_x_reg, acc_y_reg;
    logic signed [31:0] res_x_reg, res_y_reg;
    logic               sat_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ld_x_reg <= load_x;
            ld_y_reg <= load_y;
            sh_x_reg <= shift_x;
            sh_y_reg <= shift_y;
            ang_reg  <= angle_degrees;
            sc_x_reg <= scale_x;
            sc_y_reg <= scale_y;
        end
    end

    // angle mod 360: bias by two turns, then take off up to three turns
    logic signed [19:0] biased;
    logic signed [19:0] mod_next;
    always_comb
    begin
        biased = 20'(ang_reg) + 20'(ANGLE_FULL * 2);
        if (biased >= 20'(ANGLE_FULL * 3))
            mod_next = biased - 20'(ANGLE_FULL * 3);
        else if (biased >= 20'(ANGLE_FULL * 2))
            mod_next = biased - 20'(ANGLE_FULL * 2);
        else if (biased >= ANGLE_FULL)
            mod_next = biased - ANGLE_FULL;
        else
            mod_next = biased;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.reduce)
            mod_reg <= mod_next;
    end

    // quarter turns and residual in (-45, 45] degrees
    logic [1:0]           quad;
    logic signed [19:0]   resid;
    logic signed [WW-1:0] px, py, qx, qy;
    always_comb
    begin
        if (mod_reg >= 20'(ANGLE_QUARTER * 3))
        begin
            quad  = 2'd3;
            resid = mod_reg - 20'(ANGLE_QUARTER * 3);
        end
        else if (mod_reg >= 20'(ANGLE_QUARTER * 2))
        begin
            quad  = 2'd2;
            resid = mod_reg - 20'(ANGLE_QUARTER * 2);
        end
        else if (mod_reg >= ANGLE_QUARTER)
        begin
            quad  = 2'd1;
            resid = mod_reg - ANGLE_QUARTER;
        end
        else
        begin
            quad  = 2'd0;
            resid = mod_reg;
        end
        if (resid > ANGLE_EIGHTH)
        begin
            resid = resid - ANGLE_QUARTER;
            quad  = quad + 2'd1;
        end
        px = WW'(point_x_reg);
        py = WW'(point_y_reg);
        case (quad)
            2'd1:
            begin
                qx = -py;
                qy = px;
            end
            2'd2:
            begin
                qx = -px;
                qy = -py;
            end
            2'd3:
            begin
                qx = py;
                qy = -px;
            end
            default:
            begin
                qx = px;
                qy = py;
            end
        endcase
    end

    // one CORDIC micro-rotation
    logic signed [WW-1:0] dx, dy;
    logic signed [32:0]   atan_val;
    always_comb
    begin
        dx       = wy_reg >>> cmd.step_idx;
        dy       = wx_reg >>> cmd.step_idx;
        atan_val = 33'(atan_deg(cmd.step_idx));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.quad)
        begin
            wx_reg <= qx;
            wy_reg <= qy;
            z_reg  <= 33'(resid) <<< 16;
        end
        else if (cmd.step)
        begin
            if (!z_reg[32])
            begin
                wx_reg <= wx_reg - dx;
                wy_reg <= wy_reg + dy;
                z_reg  <= z_reg - atan_val;
            end
            else
            begin
                wx_reg <= wx_reg + dx;
                wy_reg <= wy_reg - dy;
                z_reg  <= z_reg + atan_val;
            end
        end
    end

    // shared multiplier: gain correction split in hi/lo halves, or scale
    logic signed [31:0] mul_a;
    logic signed [30:0] mul_b;
    always_comb
    begin
        if (cmd.mode == OP_ROTATE)
        begin
            mul_b = GAIN_Q30;
            case (cmd.mul_idx)
                2'd0:    mul_a = 32'($signed(wx_reg[WW-1:18]));
                2'd1:    mul_a = {14'd0, wx_reg[17:0]};
                2'd2:    mul_a = 32'($signed(wy_reg[WW-1:18]));
                default: mul_a = {14'd0, wy_reg[17:0]};
            endcase
        end
        else
        begin
            if (cmd.mul_idx[0])
            begin
                mul_a = point_y_reg;
                mul_b = 31'(sc_y_reg);
            end
            else
            begin
                mul_a = point_x_reg;
                mul_b = 31'(sc_x_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
    end

    logic               acc_to_y;
    logic signed [AW-1:0] acc_term;
    always_comb
    begin
        if (cmd.mode == OP_ROTATE)
        begin
            acc_to_y = cmd.acc_idx[1];
            if (!cmd.acc_idx[0])
                acc_term = AW'(prod_reg) <<< 18;
            else
                acc_term = AW'(prod_reg);
        end
        else
        begin
            acc_to_y = cmd.acc_idx[0];
            acc_term = AW'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_init)
        begin
            // rounding constant for the Q30 gain
            acc_x_reg <= (cmd.mode == OP_ROTATE) ? (AW'(1) <<< 29) : '0;
            acc_y_reg <= (cmd.mode == OP_ROTATE) ? (AW'(1) <<< 29) : '0;
        end
        else if (cmd.acc_en)
        begin
            if (acc_to_y)
                acc_y_reg <= acc_y_reg + acc_term;
            else
                acc_x_reg <= acc_x_reg + acc_term;
        end
    end

    // final value and clamp
    logic signed [RW-1:0] raw_x, raw_y;
    logic signed [AW-1:0] rx_shift, ry_shift;
    logic signed [31:0]   cl_x, cl_y;
    logic                 sat_x, sat_y;
    always_comb
    begin
        rx_shift = acc_x_reg >>> 30;
        ry_shift = acc_y_reg >>> 30;
        case (cmd.mode)
            OP_LOAD:
            begin
                raw_x = RW'(ld_x_reg);
                raw_y = RW'(ld_y_reg);
            end
            OP_TRANSLATE:
            begin
                raw_x = RW'(point_x_reg) + RW'(sh_x_reg);
                raw_y = RW'(point_y_reg) + RW'(sh_y_reg);
            end
            OP_ROTATE:
            begin
                raw_x = rx_shift[RW-1:0];
                raw_y = ry_shift[RW-1:0];
            end
            default:
            begin
                rx_shift = acc_x_reg >>> 8;
                ry_shift = acc_y_reg >>> 8;
                raw_x    = rx_shift[RW-1:0];
                raw_y    = ry_shift[RW-1:0];
            end
        endcase

        sat_x = 1'b1;
        if (raw_x > RW'(32'sh7fffffff))
            cl_x = 32'sh7fffffff;
        else if (raw_x < -(RW'(1) <<< 31))
            cl_x = 32'sh80000000;
        else
        begin
            cl_x  = raw_x[31:0];
            sat_x = 1'b0;
        end

        sat_y = 1'b1;
        if (raw_y > RW'(32'sh7fffffff))
            cl_y = 32'sh7fffffff;
        else if (raw_y < -(RW'(1) <<< 31))
            cl_y = 32'sh80000000;
        else
        begin
            cl_y  = raw_y[31:0];
            sat_y = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_x_reg <= '0;
            point_y_reg <= '0;
        end
        else if (cmd.finish)
        begin
            point_x_reg <= cl_x;
            point_y_reg <= cl_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_x_reg <= cl_x;
            res_y_reg <= cl_y;
            sat_reg   <= sat_x | sat_y;
        end
    end

    assign result_x  = res_x_reg;
    assign result_y  = res_y_reg;
    assign saturated = sat_reg;

endmodule

// File: rtl/point_rotate_translate_scale.sv
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// in       in_valid / in_ready   opcode, load_x/y, angle_degrees, shift_x/y, scale_x/y
// out      out_valid / out_ready result_x, result_y, saturated
//
// Load and translate skip straight to finish; scale uses the one shared multiplier;
// rotate takes longest, for the CORDIC iterations and the gain correction on it.
// Reset puts the point at the origin; no clearing pass.
// A finished result sits in the output register; the next item is taken
// meanwhile and holds in its last step until that register frees.

module point_rotate_translate_scale
    import prts_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] load_x,
    input  logic signed [31:0] load_y,
    input  logic signed [17:0] angle_degrees,
    input  logic signed [31:0] shift_x,
    input  logic signed [31:0] shift_y,
    input  logic signed [15:0] scale_x,
    input  logic signed [15:0] scale_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result_x,
    output logic signed [31:0] result_y,
    output logic               saturated
);

    dp_cmd_t cmd;

    prts_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    prts_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .load_x        (load_x),
        .load_y        (load_y),
        .angle_degrees (angle_degrees),
        .shift_x       (shift_x),
        .shift_y       (shift_y),
        .scale_x       (scale_x),
        .scale_y       (scale_y),
        .result_x      (result_x),
        .result_y      (result_y),
        .saturated     (saturated)
    );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import prts_pkg::*;

    localparam int    CORDIC_STEPS  = 16;
    localparam int    RANDOM_ITEMS  = 626;
    localparam int    STALL_LIMIT   = 2000;
    localparam int    HOLD_CYCLES   = 300;
    localparam int    DRAIN_CYCLES  = 40;
    localparam longint FULL_TURN    = 92160;
    localparam longint QUARTER_TURN = 23040;
    localparam longint EIGHTH_TURN  = 11520;
    localparam longint GAIN_Q30     = 652032874;
    localparam longint COORD_MAX    = 64'sd2147483647;
    localparam longint COORD_MIN    = -64'sd2147483648;

    typedef struct {
        op_t                op;
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [17:0] ang;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [15:0] kx;
        logic signed [15:0] ky;
    } point_cmd_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               sat;
    } point_t;

    typedef struct {
        point_cmd_t cmd;
        bit         typed;
        point_t     want;
    } vector_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [17:0] angle_degrees;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic               saturated;

    // atan(2^-i) in degrees, Q8.24
    longint atan_q24 [0:31] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0
    };

    longint      pos_x;
    longint      pos_y;
    point_t      expected_points[$];
    vector_row_t directed[$];
    int          errors;
    int          idle_cycles;
    int          src_idle_pct;
    int          sink_idle_pct;
    bit          hold_req;

    point_rotate_translate_scale #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .load_x       (load_x),
        .load_y       (load_y),
        .angle_degrees(angle_degrees),
        .shift_x      (shift_x),
        .shift_y      (shift_y),
        .scale_x      (scale_x),
        .scale_y      (scale_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_x     (result_x),
        .result_y     (result_y),
        .saturated    (saturated)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic longint clamp_coord(input longint v, inout logic sat);
        if (v > COORD_MAX)
        begin
            sat = 1'b1;
            return COORD_MAX;
        end
        if (v < COORD_MIN)
        begin
            sat = 1'b1;
            return COORD_MIN;
        end
        return v;
    endfunction

    // Applies one command to the tracked point and returns the new point.
    function automatic point_t next_point(input point_cmd_t c);
        longint nx, ny, m, q, r, z, t, dx, dy;
        int     i;
        point_t res;
        nx = pos_x;
        ny = pos_y;
        res.sat = 1'b0;
        case (c.op)
            OP_LOAD:
            begin
                nx = longint'(c.lx);
                ny = longint'(c.ly);
            end
            OP_ROTATE:
            begin
                m = longint'(c.ang) % FULL_TURN;
                if (m < 0)
                    m += FULL_TURN;
                q = m / QUARTER_TURN;
                r = m - q * QUARTER_TURN;
                // exactly 45 stays on this side of the quadrant
                if (r > EIGHTH_TURN)
                begin
                    r -= QUARTER_TURN;
                    q = (q + 1) & 3;
                end
                if (q == 1)
                begin
                    t = nx; nx = -ny; ny = t;
                end
                else if (q == 2)
                begin
                    nx = -nx; ny = -ny;
                end
                else if (q == 3)
                begin
                    t = nx; nx = ny; ny = -t;
                end
                z = r * 65536;
                for (i = 0; i < CORDIC_STEPS && i < 32; i++)
                begin
                    dx = ny >>> i;
                    dy = nx >>> i;
                    if (z >= 0)
                    begin
                        nx -= dx; ny += dy; z -= atan_q24[i];
                    end
                    else
                    begin
                        nx += dx; ny -= dy; z += atan_q24[i];
                    end
                end
                nx = (nx * GAIN_Q30 + (longint'(1) <<< 29)) >>> 30;
                ny = (ny * GAIN_Q30 + (longint'(1) <<< 29)) >>> 30;
            end
            OP_TRANSLATE:
            begin
                nx += longint'(c.sx);
                ny += longint'(c.sy);
            end
            default:
            begin
                nx = (nx * longint'(c.kx)) >>> 8;
                ny = (ny * longint'(c.ky)) >>> 8;
            end
        endcase
        pos_x = clamp_coord(nx, res.sat);
        pos_y = clamp_coord(ny, res.sat);
        res.x = pos_x[31:0];
        res.y = pos_y[31:0];
        return res;
    endfunction

    // Unused fields get random content so their bits toggle too.
    function automatic vector_row_t row(input op_t op, input longint a, input longint b,
                                        input bit typed, input longint ex,
                                        input longint ey, input logic es);
        vector_row_t v;
        v.cmd.op  = op;
        v.cmd.lx  = $urandom;
        v.cmd.ly  = $urandom;
        v.cmd.ang = 18'($urandom);
        v.cmd.sx  = $urandom;
        v.cmd.sy  = $urandom;
        v.cmd.kx  = 16'($urandom);
        v.cmd.ky  = 16'($urandom);
        case (op)
            OP_LOAD:      begin v.cmd.lx = 32'(a); v.cmd.ly = 32'(b); end
            OP_ROTATE:    v.cmd.ang = 18'(a);
            OP_TRANSLATE: begin v.cmd.sx = 32'(a); v.cmd.sy = 32'(b); end
            default:      begin v.cmd.kx = 16'(a); v.cmd.ky = 16'(b); end
        endcase
        v.typed  = typed;
        v.want.x = 32'(ex);
        v.want.y = 32'(ey);
        v.want.sat = es;
        return v;
    endfunction

    function automatic point_cmd_t random_cmd();
        point_cmd_t c;
        c.op  = op_t'($urandom_range(0, 3));
        c.lx  = $urandom;
        c.ly  = $urandom;
        c.ang = 18'(int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);
        c.sx  = $urandom;
        c.sy  = $urandom;
        c.kx  = 16'($urandom);
        c.ky  = 16'($urandom);
        // keep half the points and most steps moderate so rotations do not just saturate
        if ($urandom_range(0, 1))
        begin
            c.lx = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            c.ly = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        end
        if ($urandom_range(0, 9) != 0)
        begin
            c.sx = int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            c.sy = int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        end
        if ($urandom_range(0, 6) != 0)
        begin
            c.kx = 16'(($urandom_range(0, 1) ? 16'sh0100 : -16'sh0100)
                       + int'($urandom_range(0, 128)) - 64);
            c.ky = 16'(($urandom_range(0, 1) ? 16'sh0100 : -16'sh0100)
                       + int'($urandom_range(0, 128)) - 64);
        end
        return c;
    endfunction

    // Drives one command, waits for the transfer and queues its expected point.
    task automatic send_cmd(input point_cmd_t c, input bit typed, input point_t want);
        point_t p;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        opcode        <= c.op;
        load_x        <= c.lx;
        load_y        <= c.ly;
        angle_degrees <= c.ang;
        shift_x       <= c.sx;
        shift_y       <= c.sy;
        scale_x       <= c.kx;
        scale_y       <= c.ky;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = next_point(c);
        expected_points.push_back(typed ? want : p);
        @(negedge clk);
    endtask

    // receiver side
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
            else
                out_ready <= rst_n && ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
                report_error($sformatf("unexpected result x=%0d y=%0d sat=%0d",
                                       result_x, result_y, saturated));
            else
            begin
                if (result_x !== expected_points[0].x)
                    report_error($sformatf("result_x got %0d expected %0d",
                                           result_x, expected_points[0].x));
                if (result_y !== expected_points[0].y)
                    report_error($sformatf("result_y got %0d expected %0d",
                                           result_y, expected_points[0].y));
                if (saturated !== expected_points[0].sat)
                    report_error($sformatf("saturated got %0d expected %0d",
                                           saturated, expected_points[0].sat));
                void'(expected_points.pop_front());
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        point_t none;
        int     n;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = OP_LOAD;
        load_x        = '0;
        load_y        = '0;
        angle_degrees = '0;
        shift_x       = '0;
        shift_y       = '0;
        scale_x       = '0;
        scale_y       = '0;
        errors        = 0;
        idle_cycles   = 0;
        hold_req      = 1'b0;
        src_idle_pct  = 24;
        sink_idle_pct = 50;
        pos_x         = 0;
        pos_y         = 0;
        none          = '{0, 0, 1'b0};

        // op, a, b, typed, expected x, expected y, expected sat
        directed.push_back(row(OP_SCALE, 'h7fff, 'h8000, 1, 0, 0, 0));
        directed.push_back(row(OP_TRANSLATE, COORD_MAX, COORD_MIN, 1,
                               COORD_MAX, COORD_MIN, 0));
        directed.push_back(row(OP_TRANSLATE, 1, -1, 1, COORD_MAX, COORD_MIN, 1));
        directed.push_back(row(OP_SCALE, 'h0100, 'h0100, 1, COORD_MAX, COORD_MIN, 0));
        directed.push_back(row(OP_SCALE, 'hff00, 'hff00, 1, -COORD_MAX, COORD_MAX, 1));
        directed.push_back(row(OP_LOAD, COORD_MIN, COORD_MAX, 1, COORD_MIN, COORD_MAX, 0));
        directed.push_back(row(OP_SCALE, 'h8000, 'h7fff, 1, COORD_MAX, COORD_MAX, 1));
        directed.push_back(row(OP_LOAD, COORD_MIN, 0, 1, COORD_MIN, 0, 0));
        directed.push_back(row(OP_ROTATE, QUARTER_TURN, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_LOAD, 'h10000, 0, 1, 'h10000, 0, 0));
        directed.push_back(row(OP_ROTATE, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_ROTATE, EIGHTH_TURN, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_ROTATE, -EIGHTH_TURN, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_ROTATE, QUARTER_TURN + EIGHTH_TURN, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_ROTATE, FULL_TURN, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_ROTATE, -FULL_TURN, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_ROTATE, 2 * QUARTER_TURN, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_ROTATE, -3 * QUARTER_TURN, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_ROTATE, EIGHTH_TURN + 1, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_LOAD, -3, 5, 1, -3, 5, 0));
        directed.push_back(row(OP_SCALE, 'h0080, 'h0080, 1, -2, 2, 0));
        directed.push_back(row(OP_TRANSLATE, -5, 'h7ffffffd, 1, -7, COORD_MAX, 0));
        directed.push_back(row(OP_LOAD, 'h12345678, -'h0abcdef0, 0, 0, 0, 0));
        directed.push_back(row(OP_ROTATE, 5000, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_SCALE, 'hfe80, 'h0155, 0, 0, 0, 0));

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[k])
            send_cmd(directed[k].cmd, directed[k].typed, directed[k].want);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 50;
                sink_idle_pct = 24;
            end
            if (n == 2 * RANDOM_ITEMS / 3)
            begin
                // receiver holds off while the sender keeps offering back to back
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                hold_req      = 1'b1;
            end
            send_cmd(random_cmd(), 1'b0, none);
        end
        in_valid <= 1'b0;

        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// File: point_rotate_translate_scale.f
rtl/prts_pkg.sv
rtl/prts_ctrl.sv
rtl/prts_datapath.sv
rtl/point_rotate_translate_scale.sv
verif/testbench.sv
